// ----- hw/rtl/sdik_pkg.sv -----
// ----------------------------------------------------------------------------
// sdik_pkg
// Types and constants shared by the swerve drive inverse kinematics block.
// ----------------------------------------------------------------------------
package sdik_pkg;

    // Input word kinds
    localparam logic [2:0] KIND_CHASSIS  = 3'd0;
    localparam logic [2:0] KIND_RELATIVE = 3'd1;
    localparam logic [2:0] KIND_ABSOLUTE = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_READ     = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_SPEED_SCALE    = 3'd0;
    localparam logic [2:0] REG_ROT_SCALE      = 3'd1;
    localparam logic [2:0] REG_HEADING_OFFSET = 3'd2;
    localparam logic [2:0] REG_ZERO_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd4;
    localparam logic [2:0] REG_STEER_OFFSETS  = 3'd5;
    localparam logic [2:0] REG_STEER_SIGN     = 3'd6;

    localparam int XW = 34;   // CORDIC x/y width
    localparam int ZW = 26;   // CORDIC angle width, 2^24 per turn
    localparam int MW = 59;   // multiplier product width
    localparam int VW = 18;   // module vector component width

    localparam logic signed [24:0] INV_GAIN     = 25'sd39797;
    localparam logic signed [ZW-1:0] HALF_TURN  = 26'sd8388608;
    localparam logic signed [ZW-1:0] QUARTER    = 26'sd4194304;
    localparam logic [3:0] LAST_STEP            = 4'd15;
    localparam logic [1:0] LAST_MODULE          = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_ROT    = 12'b000000000010,
        S_RMX    = 12'b000000000100,
        S_RMY    = 12'b000000001000,
        S_OMUL   = 12'b000000010000,
        S_ROTR   = 12'b000000100000,
        S_VLOAD  = 12'b000001000000,
        S_VEC    = 12'b000010000000,
        S_VMUL   = 12'b000100000000,
        S_UPD    = 12'b001000000000,
        S_RDMUL  = 12'b010000000000,
        S_RDOUT  = 12'b100000000000
    } state_t;

    // Arctangent of 2^-i in 2^24 per turn
    function automatic logic signed [ZW-1:0] atan_angle(input logic [3:0] i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                4'd0:    r = 26'sd2097152;
                4'd1:    r = 26'sd1238021;
                4'd2:    r = 26'sd654136;
                4'd3:    r = 26'sd332050;
                4'd4:    r = 26'sd166669;
                4'd5:    r = 26'sd83416;
                4'd6:    r = 26'sd41718;
                4'd7:    r = 26'sd20860;
                4'd8:    r = 26'sd10430;
                4'd9:    r = 26'sd5215;
                4'd10:   r = 26'sd2608;
                4'd11:   r = 26'sd1304;
                4'd12:   r = 26'sd652;
                4'd13:   r = 26'sd326;
                4'd14:   r = 26'sd163;
                default: r = 26'sd81;
            endcase
            return r;
        end
    endfunction

    // Module index to 16-bit slot of the steering offset register
    function automatic logic [1:0] offset_slot(input logic [1:0] m);
        logic [1:0] r;
        begin
            unique case (m)
                2'd0:    r = 2'd0;
                2'd1:    r = 2'd2;
                2'd2:    r = 2'd3;
                default: r = 2'd1;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/swerve_drive_inverse_kinematics_top.sv -----
// ----------------------------------------------------------------------------
// swerve_drive_inverse_kinematics_top
// Four-module swerve inverse kinematics with one shared CORDIC stage.
// ----------------------------------------------------------------------------
// A frame-rotated command word keeps the block busy for its frame rotation and
// the four module passes, while a chassis-frame command skips the frame rotation:
// one CORDIC stage runs 16 iterations for the frame rotation and again for
// each module's speed and heading (load, 16 steps, multiply, update), and one
// shared multiplier applies gains and scales. A module whose vector is zero
// skips its CORDIC pass and goes from load straight to update. Tick and ignored
// words leave the block idle. A read forms each result word in turn (multiply,
// form, hand-off), and an output stall holds it. in_ready is low while a word is in
// work or a result word waits.
module swerve_drive_inverse_kinematics_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          kind,
    input  logic signed [15:0]  vel_x,
    input  logic signed [15:0]  vel_y,
    input  logic signed [15:0]  omega,
    input  logic [15:0]         angle_a,
    input  logic [15:0]         angle_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          module_res,
    output logic signed [31:0]  wheel_rate,
    output logic signed [31:0]  steer_pos,
    output logic                steer_hold,
    output logic                last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    localparam int XW = sdik_pkg::XW;
    localparam int ZW = sdik_pkg::ZW;
    localparam int MW = sdik_pkg::MW;
    localparam int VW = sdik_pkg::VW;

    // Configuration registers
    logic [23:0] speed_scale_reg;
    logic [15:0] rot_scale_reg, heading_offset_reg, zero_threshold_reg, timeout_ticks_reg;
    logic [63:0] steer_offsets_reg;
    logic        steer_sign_reg;

    // Control and datapath registers
    sdik_pkg::state_t state_reg, state_next;
    logic                 rot_mode_reg, rot_mode_next;
    logic [3:0]           it_reg, it_next;
    logic [1:0]           mod_reg, mod_next;
    logic signed [XW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;
    logic signed [MW-1:0] mul_reg, mul_next;
    logic signed [VW-1:0] tx_reg, tx_next, ty_reg, ty_next, rot_reg, rot_next;
    logic signed [15:0]   omega_reg, omega_next;
    logic                 vzero_reg, vzero_next;
    logic [15:0]          age_reg, age_next;
    logic [15:0]          turns_reg [4];
    logic [15:0]          turns_next [4];
    logic [15:0]          angle_reg [4];
    logic [15:0]          angle_next [4];
    logic signed [15:0]   speed_reg [4];
    logic signed [15:0]   speed_next [4];
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_mod_reg, out_mod_next;
    logic signed [31:0]   out_rate_reg, out_rate_next, out_pos_reg, out_pos_next;
    logic                 out_hold_reg, out_hold_next, out_last_reg, out_last_next;

    // Shared datapath signals
    logic                 in_acc, out_acc, cfg_wr;
    logic signed [XW-1:0] dx, dy, vx_x, vy_x;
    logic signed [ZW-1:0] atan_z, z_load;
    logic                 cw;
    logic signed [XW-1:0] mul_a;
    logic signed [24:0]   mul_b;
    logic signed [MW-1:0] rnd30, rnd20, rnd8;
    logic [15:0]          rot_ang;
    logic signed [VW-1:0] mvx, mvy;
    logic [19:0]          mag;
    logic [23:0]          head_sum;
    logic [15:0]          head, prev, d1, dsel;
    logic                 big;
    logic signed [17:0]   na;
    logic [14:0]          sp;
    logic signed [50:0]   wr_full;
    logic signed [31:0]   wr_sat;
    logic [31:0]          cumu, pos;
    logic [15:0]          offs;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid_reg && out_ready;
    assign cfg_wr  = psel && penable && pwrite && pready;

    assign in_ready   = (state_reg == sdik_pkg::S_IDLE) && !out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign module_res = out_mod_reg;
    assign wheel_rate = out_rate_reg;
    assign steer_pos  = out_pos_reg;
    assign steer_hold = out_hold_reg;
    assign last       = out_last_reg;
    assign pready     = 1'b1;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg    <= 24'd256;
            rot_scale_reg      <= 16'd16384;
            heading_offset_reg <= 16'd0;
            zero_threshold_reg <= 16'd2;
            timeout_ticks_reg  <= 16'd300;
            steer_offsets_reg  <= 64'd0;
            steer_sign_reg     <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                sdik_pkg::REG_SPEED_SCALE:    speed_scale_reg    <= pwdata[23:0];
                sdik_pkg::REG_ROT_SCALE:      rot_scale_reg      <= pwdata[15:0];
                sdik_pkg::REG_HEADING_OFFSET: heading_offset_reg <= pwdata[15:0];
                sdik_pkg::REG_ZERO_THRESHOLD: zero_threshold_reg <= pwdata[15:0];
                sdik_pkg::REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= pwdata[15:0];
                sdik_pkg::REG_STEER_OFFSETS:  steer_offsets_reg  <= pwdata;
                sdik_pkg::REG_STEER_SIGN:     steer_sign_reg     <= pwdata[0];
                default:                      ;
            endcase
        end
    end

    // Register read
    always_comb
    begin
        unique case (paddr[5:3])
            sdik_pkg::REG_SPEED_SCALE:    prdata = {40'd0, speed_scale_reg};
            sdik_pkg::REG_ROT_SCALE:      prdata = {48'd0, rot_scale_reg};
            sdik_pkg::REG_HEADING_OFFSET: prdata = {48'd0, heading_offset_reg};
            sdik_pkg::REG_ZERO_THRESHOLD: prdata = {48'd0, zero_threshold_reg};
            sdik_pkg::REG_TIMEOUT_TICKS:  prdata = {48'd0, timeout_ticks_reg};
            sdik_pkg::REG_STEER_OFFSETS:  prdata = steer_offsets_reg;
            sdik_pkg::REG_STEER_SIGN:     prdata = {63'd0, steer_sign_reg};
            default:                      prdata = 64'd0;
        endcase
    end

    // CORDIC stage: rotation mode steers z to zero, vectoring mode steers y to zero
    assign dx     = cy_reg >>> it_reg;
    assign dy     = cx_reg >>> it_reg;
    assign atan_z = sdik_pkg::atan_angle(it_reg);
    assign cw     = (state_reg == sdik_pkg::S_ROT) ? cz_reg[ZW-1] : !cy_reg[XW-1];

    // Frame rotation angle and input vector scaled by 2^14
    assign rot_ang = (kind == sdik_pkg::KIND_RELATIVE) ? angle_a
                                                       : angle_a + angle_b - heading_offset_reg;
    assign z_load  = {{(ZW-24){rot_ang[15]}}, rot_ang, 8'h00};

    // Module vector: LF (-,+), LB (-,-), RB (+,-), RF (+,+)
    assign mvx = (mod_reg[1]) ? tx_reg + rot_reg : tx_reg - rot_reg;
    assign mvy = (mod_reg == 2'd0 || mod_reg == 2'd3) ? ty_reg + rot_reg : ty_reg - rot_reg;
    assign vx_x = {{(XW-VW-14){mvx[VW-1]}}, mvx, 14'd0};
    assign vy_x = {{(XW-VW-14){mvy[VW-1]}}, mvy, 14'd0};

    // Shared multiplier operands
    always_comb
    begin
        mul_a = sdik_pkg::XW'(0);
        mul_b = 25'sd0;
        unique case (state_reg)
            sdik_pkg::S_RMX, sdik_pkg::S_VMUL:
            begin
                mul_a = cx_reg;
                mul_b = sdik_pkg::INV_GAIN;
            end
            sdik_pkg::S_RMY:
            begin
                mul_a = cy_reg;
                mul_b = sdik_pkg::INV_GAIN;
            end
            sdik_pkg::S_OMUL:
            begin
                mul_a = {{(XW-16){omega_reg[15]}}, omega_reg};
                mul_b = {9'd0, rot_scale_reg};
            end
            sdik_pkg::S_RDMUL:
            begin
                mul_a = {{(XW-16){speed_reg[mod_reg][15]}}, speed_reg[mod_reg]};
                mul_b = {1'b0, speed_scale_reg};
            end
            default:
            begin
                mul_a = sdik_pkg::XW'(0);
                mul_b = 25'sd0;
            end
        endcase
    end

    // Rounding of the product, half up
    assign rnd30 = mul_reg + (MW'(1) <<< 29);
    assign rnd20 = mul_reg + (MW'(1) <<< 19);
    assign rnd8  = mul_reg + MW'(128);

    // Speed and heading of the module vector
    assign mag      = vzero_reg ? 20'd0 : rnd30[49:30];
    assign head_sum = cz_reg[23:0] + 24'd128;
    assign head     = vzero_reg ? 16'd0 : head_sum[23:8];
    assign prev     = angle_reg[mod_reg];
    assign d1       = prev - head;
    assign big      = ($signed(d1) >= 16'sd16384) || ($signed(d1) <= -16'sd16384);
    assign dsel     = big ? (d1 ^ 16'h8000) : d1;
    assign na       = $signed({2'b00, prev}) - $signed({{2{dsel[15]}}, dsel});
    assign sp       = (mag > 20'd32767) ? 15'h7fff : mag[14:0];

    // Read word: wheel rate with saturation and cumulative steering goal
    assign wr_full = rnd8[58:8];
    always_comb
    begin
        priority if (wr_full > 51'sd2147483647)
            wr_sat = 32'sh7fffffff;
        else if (wr_full < -51'sd2147483648)
            wr_sat = 32'sh80000000;
        else
            wr_sat = wr_full[31:0];
    end

    assign cumu = {turns_reg[mod_reg], angle_reg[mod_reg]};
    always_comb
    begin
        unique case (sdik_pkg::offset_slot(mod_reg))
            2'd0:    offs = steer_offsets_reg[15:0];
            2'd1:    offs = steer_offsets_reg[31:16];
            2'd2:    offs = steer_offsets_reg[47:32];
            default: offs = steer_offsets_reg[63:48];
        endcase
    end
    assign pos = (steer_sign_reg ? (32'd0 - cumu) : cumu) + {{16{offs[15]}}, offs};

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        rot_mode_next  = rot_mode_reg;
        it_next        = it_reg;
        mod_next       = mod_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        mul_next       = mul_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        rot_next       = rot_reg;
        omega_next     = omega_reg;
        vzero_next     = vzero_reg;
        age_next       = age_reg;
        turns_next     = turns_reg;
        angle_next     = angle_reg;
        speed_next     = speed_reg;
        out_valid_next = out_valid_reg;
        out_mod_next   = out_mod_reg;
        out_rate_next  = out_rate_reg;
        out_pos_next   = out_pos_reg;
        out_hold_next  = out_hold_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            sdik_pkg::S_IDLE:
            begin
                // Drop the word on hand-off; step to the next module or finish
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (mod_reg != sdik_pkg::LAST_MODULE)
                    begin
                        mod_next   = mod_reg + 2'd1;
                        state_next = sdik_pkg::S_RDMUL;
                    end
                end
                if (in_acc)
                begin
                    omega_next = omega;
                    it_next    = 4'd0;
                    mod_next   = 2'd0;
                    if (kind == sdik_pkg::KIND_CHASSIS)
                    begin
                        rot_mode_next = 1'b0;
                        tx_next       = VW'(vel_x);
                        ty_next       = VW'(vel_y);
                        state_next    = sdik_pkg::S_OMUL;
                    end
                    else if (kind == sdik_pkg::KIND_RELATIVE ||
                             kind == sdik_pkg::KIND_ABSOLUTE)
                    begin
                        rot_mode_next = 1'b1;
                        if (z_load > sdik_pkg::QUARTER || z_load < -sdik_pkg::QUARTER)
                        begin
                            cx_next = -({{(XW-30){vel_x[15]}}, vel_x, 14'd0});
                            cy_next = -({{(XW-30){vel_y[15]}}, vel_y, 14'd0});
                            cz_next = (z_load > 0) ? z_load - sdik_pkg::HALF_TURN
                                                   : z_load + sdik_pkg::HALF_TURN;
                        end
                        else
                        begin
                            cx_next = {{(XW-30){vel_x[15]}}, vel_x, 14'd0};
                            cy_next = {{(XW-30){vel_y[15]}}, vel_y, 14'd0};
                            cz_next = z_load;
                        end
                        state_next = sdik_pkg::S_ROT;
                    end
                    else if (kind == sdik_pkg::KIND_TICK)
                    begin
                        if (age_reg != 16'hffff)
                            age_next = age_reg + 16'd1;
                    end
                    else if (kind == sdik_pkg::KIND_READ)
                    begin
                        state_next = sdik_pkg::S_RDMUL;
                    end
                    else
                    begin
                        // Drop spare kinds
                    end
                end
            end

            sdik_pkg::S_ROT, sdik_pkg::S_VEC:
            begin
                // Advance one CORDIC iteration
                if (cw)
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan_z;
                end
                else
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan_z;
                end
                it_next = it_reg + 4'd1;
                if (it_reg == sdik_pkg::LAST_STEP)
                    state_next = (state_reg == sdik_pkg::S_ROT) ? sdik_pkg::S_RMX
                                                                : sdik_pkg::S_VMUL;
            end

            sdik_pkg::S_RMX:
            begin
                mul_next   = mul_a * mul_b;
                state_next = sdik_pkg::S_RMY;
            end

            sdik_pkg::S_RMY:
            begin
                tx_next    = rnd30[30+VW-1:30];
                mul_next   = mul_a * mul_b;
                state_next = sdik_pkg::S_OMUL;
            end

            sdik_pkg::S_OMUL:
            begin
                if (rot_mode_reg)
                    ty_next = rnd30[30+VW-1:30];
                mul_next   = mul_a * mul_b;
                state_next = sdik_pkg::S_ROTR;
            end

            sdik_pkg::S_ROTR:
            begin
                rot_next   = rnd20[20+VW-1:20];
                state_next = sdik_pkg::S_VLOAD;
            end

            sdik_pkg::S_VLOAD:
            begin
                // Load the module vector, fold into the right half plane
                it_next    = 4'd0;
                vzero_next = (mvx == '0) && (mvy == '0);
                if (mvx < 0)
                begin
                    cx_next = -vx_x;
                    cy_next = -vy_x;
                    cz_next = sdik_pkg::HALF_TURN;
                end
                else
                begin
                    cx_next = vx_x;
                    cy_next = vy_x;
                    cz_next = '0;
                end
                state_next = ((mvx == '0) && (mvy == '0)) ? sdik_pkg::S_UPD
                                                          : sdik_pkg::S_VEC;
            end

            sdik_pkg::S_VMUL:
            begin
                mul_next   = mul_a * mul_b;
                state_next = sdik_pkg::S_UPD;
            end

            sdik_pkg::S_UPD:
            begin
                // Hold heading at zero speed, else steer within a quarter turn
                if (mag < {4'd0, zero_threshold_reg})
                begin
                    speed_next[mod_reg] = 16'sd0;
                end
                else
                begin
                    if (na < 0)
                        turns_next[mod_reg] = turns_reg[mod_reg] - 16'd1;
                    else if (na > 18'sd65535)
                        turns_next[mod_reg] = turns_reg[mod_reg] + 16'd1;
                    angle_next[mod_reg] = na[15:0];
                    speed_next[mod_reg] = big ? -$signed({1'b0, sp}) : $signed({1'b0, sp});
                end
                if (mod_reg == sdik_pkg::LAST_MODULE)
                begin
                    age_next   = 16'd0;
                    state_next = sdik_pkg::S_IDLE;
                end
                else
                begin
                    mod_next   = mod_reg + 2'd1;
                    state_next = sdik_pkg::S_VLOAD;
                end
            end

            sdik_pkg::S_RDMUL:
            begin
                mul_next   = mul_a * mul_b;
                state_next = sdik_pkg::S_RDOUT;
            end

            sdik_pkg::S_RDOUT:
            begin
                // Form the read word from the product, stop with hold when stale
                out_valid_next = 1'b1;
                out_mod_next   = mod_reg;
                out_last_next  = (mod_reg == sdik_pkg::LAST_MODULE);
                if (age_reg > timeout_ticks_reg)
                begin
                    out_rate_next = 32'sd0;
                    out_pos_next  = 32'sd0;
                    out_hold_next = 1'b1;
                end
                else
                begin
                    out_rate_next = wr_sat;
                    out_pos_next  = $signed(pos);
                    out_hold_next = 1'b0;
                end
                state_next = sdik_pkg::S_IDLE;
            end

            default:
            begin
                state_next = sdik_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdik_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            age_reg       <= 16'hffff;
            mod_reg       <= 2'd0;
            it_reg        <= 4'd0;
            rot_mode_reg  <= 1'b0;
            vzero_reg     <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                turns_reg[i] <= 16'd0;
                angle_reg[i] <= 16'd0;
                speed_reg[i] <= 16'sd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            age_reg       <= age_next;
            mod_reg       <= mod_next;
            it_reg        <= it_next;
            rot_mode_reg  <= rot_mode_next;
            vzero_reg     <= vzero_next;
            turns_reg     <= turns_next;
            angle_reg     <= angle_next;
            speed_reg     <= speed_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        mul_reg      <= mul_next;
        tx_reg       <= tx_next;
        ty_reg       <= ty_next;
        rot_reg      <= rot_next;
        omega_reg    <= omega_next;
        out_mod_reg  <= out_mod_next;
        out_rate_reg <= out_rate_next;
        out_pos_reg  <= out_pos_next;
        out_hold_reg <= out_hold_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the swerve drive inverse kinematics block. Words go
// in through a valid/ready channel with random gaps. An internal fixed-point
// predictor computes the module goals for every read. Each result word is
// checked against the oldest expected goal. Register settings run from reset
// values through both extremes to random values.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
    localparam int         CYCLE_LIMIT      = 1000000;
    localparam int         DRAIN_CYCLES     = 200;
    localparam int         STALL_CYCLES     = 400;

    typedef struct {
        logic [1:0]  module_idx;
        logic [31:0] rate;
        logic [31:0] pos;
        logic        hold;
        logic        last_word;
    } goal_t;

    // Swerve predictor with its own registers, module state and goal queue
    class swerve_scoreboard;
        int unsigned cfg_speed_scale, cfg_rot_scale, cfg_heading, cfg_zero_thr;
        int unsigned cfg_timeout, cfg_sign;
        logic [63:0] cfg_offsets;
        logic [15:0] turns[4];
        logic [15:0] angle[4];
        int          speed[4];
        logic [15:0] age;
        goal_t       goals[$];
        int          atan_steps[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                        41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                        163, 81};

        function new();
            cfg_speed_scale = 256; cfg_rot_scale = 16384; cfg_heading = 0;
            cfg_zero_thr = 2; cfg_timeout = 300; cfg_offsets = '0; cfg_sign = 0;
            for (int m = 0; m < 4; m++)
            begin
                turns[m] = '0; angle[m] = '0; speed[m] = 0;
            end
            age = 16'hFFFF;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                sdik_pkg::REG_SPEED_SCALE:    cfg_speed_scale = v[23:0];
                sdik_pkg::REG_ROT_SCALE:      cfg_rot_scale = v[15:0];
                sdik_pkg::REG_HEADING_OFFSET: cfg_heading = v[15:0];
                sdik_pkg::REG_ZERO_THRESHOLD: cfg_zero_thr = v[15:0];
                sdik_pkg::REG_TIMEOUT_TICKS:  cfg_timeout = v[15:0];
                sdik_pkg::REG_STEER_OFFSETS:  cfg_offsets = v;
                sdik_pkg::REG_STEER_SIGN:     cfg_sign = v[0];
                default: ;
            endcase
        endfunction

        function longint round_down(longint v, int n);
            return (v + (longint'(1) << (n - 1))) >>> n;
        endfunction

        // Turn (vx, vy) by a binary angle with the circular CORDIC
        function void turn_vector(int vx, int vy, logic [15:0] a, output int ox,
                                  output int oy);
            longint x, y, dx, dy;
            int z;
            x = longint'(vx) * 16384;
            y = longint'(vy) * 16384;
            z = int'({a, 8'h00});
            if (z >= 32'sh800000) z -= 32'sh1000000;
            if (z > 32'sh400000 || z < -32'sh400000)
            begin
                x = -x; y = -y;
                z = (z > 0) ? z - 32'sh800000 : z + 32'sh800000;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0) begin x -= dx; y += dy; z -= atan_steps[i]; end
                else        begin x += dx; y -= dy; z += atan_steps[i]; end
            end
            ox = int'(round_down(x * 39797, 30));
            oy = int'(round_down(y * 39797, 30));
        endfunction

        // Magnitude and heading of a module vector
        function void polar(int vx, int vy, output int mag, output logic [15:0] head);
            longint x, y, dx, dy;
            logic [31:0] z;
            logic [31:0] zr;
            if (vx == 0 && vy == 0)
            begin
                mag = 0; head = '0;
                return;
            end
            x = longint'(vx) * 16384;
            y = longint'(vy) * 16384;
            z = 0;
            if (x < 0) begin x = -x; y = -y; z = 32'h800000; end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i; dy = x >>> i;
                if (y >= 0) begin x += dx; y -= dy; z += atan_steps[i]; end
                else        begin x -= dx; y += dy; z -= atan_steps[i]; end
            end
            mag = int'(round_down(x * 39797, 30));
            zr = (z + 32'd128) >> 8;
            head = zr[15:0];
        endfunction

        // Steer one module to the nearest heading, reversing if needed
        function void steer_module(int m, int vx, int vy);
            int mag, d, na;
            logic [15:0] head, diff;
            bit rev;
            polar(vx, vy, mag, head);
            if (mag < int'(cfg_zero_thr))
            begin
                speed[m] = 0;
                return;
            end
            rev = 0;
            diff = angle[m] - head;
            d = int'(signed'(diff));
            if (d >= 16384 || d <= -16384)
            begin
                rev = 1;
                diff = angle[m] - (head + 16'h8000);
                d = int'(signed'(diff));
            end
            na = int'(angle[m]) - d;
            if (na < 0) begin na += 65536; turns[m] = turns[m] - 1'b1; end
            else if (na >= 65536) begin na -= 65536; turns[m] = turns[m] + 1'b1; end
            angle[m] = na[15:0];
            if (mag > 32767) mag = 32767;
            speed[m] = rev ? -mag : mag;
        endfunction

        // Advance the model by one accepted input word
        function void note_input(logic [2:0] k, logic signed [15:0] vx,
                                 logic signed [15:0] vy, logic signed [15:0] om,
                                 logic [15:0] aa, logic [15:0] ab);
            int tx, ty, rot;
            longint r, cumu;
            logic [31:0] p;
            logic [15:0] off, ang;
            goal_t g;
            if (k == sdik_pkg::KIND_CHASSIS || k == sdik_pkg::KIND_RELATIVE ||
                k == sdik_pkg::KIND_ABSOLUTE)
            begin
                tx = vx; ty = vy;
                if (k == sdik_pkg::KIND_RELATIVE) turn_vector(vx, vy, aa, tx, ty);
                else if (k == sdik_pkg::KIND_ABSOLUTE)
                begin
                    ang = aa + ab - cfg_heading[15:0];
                    turn_vector(vx, vy, ang, tx, ty);
                end
                rot = int'(round_down(longint'(om) * cfg_rot_scale, 20));
                steer_module(0, tx - rot, ty + rot);
                steer_module(1, tx - rot, ty - rot);
                steer_module(2, tx + rot, ty - rot);
                steer_module(3, tx + rot, ty + rot);
                age = '0;
            end
            else if (k == sdik_pkg::KIND_TICK)
            begin
                if (age != 16'hFFFF) age++;
            end
            else if (k == sdik_pkg::KIND_READ)
            begin
                for (int m = 0; m < 4; m++)
                begin
                    g.module_idx = m[1:0];
                    g.last_word = (m == 3);
                    if (int'(age) > int'(cfg_timeout))
                    begin
                        g.rate = '0; g.pos = '0; g.hold = 1'b1;
                    end
                    else
                    begin
                        r = round_down(longint'(speed[m]) * cfg_speed_scale, 8);
                        if (r > 64'sh7FFFFFFF) r = 64'sh7FFFFFFF;
                        if (r < -64'sh80000000) r = -64'sh80000000;
                        cumu = longint'(signed'(turns[m])) * 65536 + angle[m];
                        p = cumu[31:0];
                        if (cfg_sign) p = -p;
                        off = cfg_offsets[16 * offset_index(m) +: 16];
                        p = p + {{16{off[15]}}, off};
                        g.rate = r[31:0]; g.pos = p; g.hold = 1'b0;
                    end
                    goals.insert(goals.size(), g);
                end
            end
        endfunction

        function int offset_index(int m);
            case (m)
                0: return 0;
                1: return 2;
                2: return 3;
                default: return 1;
            endcase
        endfunction

        function int pending();
            return goals.size();
        endfunction

        // Compare one result word with the oldest goal; empty string means match
        function string check_result(logic [1:0] mi, logic [31:0] rate, logic [31:0] pos,
                                     logic hold, logic lw);
            goal_t g;
            if (goals.size() == 0)
                return $sformatf("unexpected word module %0d", mi);
            g = goals.pop_front();
            if (mi !== g.module_idx || rate !== g.rate || pos !== g.pos ||
                hold !== g.hold || lw !== g.last_word)
                return $sformatf({"got m%0d rate %0d pos %0d hold %0b last %0b, ",
                                  "want m%0d rate %0d pos %0d hold %0b last %0b"},
                                 mi, $signed(rate), $signed(pos), hold, lw, g.module_idx,
                                 $signed(g.rate), $signed(g.pos), g.hold, g.last_word);
            return "";
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid, in_ready;
    logic [2:0]         kind;
    logic signed [15:0] vel_x, vel_y, omega;
    logic [15:0]        angle_a, angle_b;
    logic               out_valid, out_ready;
    logic [1:0]         module_res;
    logic signed [31:0] wheel_rate, steer_pos;
    logic               steer_hold, last;
    logic               psel, penable, pwrite, pready;
    logic [5:0]         paddr;
    logic [63:0]        pwdata, prdata;

    swerve_scoreboard goal_board = new();
    int  mismatches = 0;
    int  cycle_count = 0;
    int  send_idle_pct, recv_idle_pct;
    int  stall_requests = 0;
    int  stall_served = 0;
    int  stall_left = 0;

    swerve_drive_inverse_kinematics_top i_dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report(string msg);
        $display("mismatch @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Check every accepted result word
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            msg = goal_board.check_result(module_res, wheel_rate, steer_pos, steer_hold,
                                          last);
            if (msg != "") report(msg);
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (stall_requests != stall_served)
        begin
            stall_served = stall_requests;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Setup and access phase, then back to idle before returning
    task automatic reg_write(logic [2:0] idx, logic [63:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        goal_board.write_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (goal_board.pending() != 0);
    endtask

    // Drain, let any command in work finish, then load all registers
    task automatic load_regs(logic [23:0] ss, logic [15:0] rs, logic [15:0] ho,
                             logic [15:0] zt, logic [15:0] tt, logic [63:0] off, logic sg);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        reg_write(sdik_pkg::REG_SPEED_SCALE, 64'(ss));
        reg_write(sdik_pkg::REG_ROT_SCALE, 64'(rs));
        reg_write(sdik_pkg::REG_HEADING_OFFSET, 64'(ho));
        reg_write(sdik_pkg::REG_ZERO_THRESHOLD, 64'(zt));
        reg_write(sdik_pkg::REG_TIMEOUT_TICKS, 64'(tt));
        reg_write(sdik_pkg::REG_STEER_OFFSETS, off);
        reg_write(sdik_pkg::REG_STEER_SIGN, 64'(sg));
    endtask

    // Offer one word, hold it until accepted
    task automatic send_word(logic [2:0] k, logic [15:0] vx, logic [15:0] vy,
                             logic [15:0] om, logic [15:0] aa, logic [15:0] ab);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k; vel_x <= vx; vel_y <= vy; omega <= om;
        angle_a <= aa; angle_b <= ab;
        do @(posedge clk); while (!in_ready);
        goal_board.note_input(k, vx, vy, om, aa, ab);
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(7))
            0:       return $urandom_range(65535);
            1:       return 16'h0000;
            default: return 16'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Mostly commands and reads with random content, some ticks and spare kinds
    task automatic send_random();
        int pick;
        logic [2:0] k;
        pick = $urandom_range(99);
        if (pick < 45)
            k = 3'($urandom_range(sdik_pkg::KIND_CHASSIS, sdik_pkg::KIND_ABSOLUTE));
        else if (pick < 65) k = sdik_pkg::KIND_TICK;
        else if (pick < 95) k = sdik_pkg::KIND_READ;
        else                k = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        send_word(k, rand_vel(), rand_vel(),
                  ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : rand_vel(),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0; kind = sdik_pkg::KIND_TICK;
        vel_x = '0; vel_y = '0; omega = '0; angle_a = '0; angle_b = '0;
        out_ready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle_pct = 19; recv_idle_pct = 71;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: stale read, saturated tick, spare kinds, field extremes
        send_word(sdik_pkg::KIND_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_TICK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(KIND_SPARE_FIRST, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_word(KIND_SPARE_LAST, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_CHASSIS, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_CHASSIS, 16'h7FFF, 16'h8000, 16'h8000, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_CHASSIS, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_CHASSIS, 16'hFF00, 16'h0001, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_RELATIVE, 16'h0200, 16'h0100, 16'h1000, 16'h4000, 16'h0);
        send_word(sdik_pkg::KIND_RELATIVE, 16'h8000, 16'h8000, 16'h0, 16'hC001, 16'h0);
        send_word(sdik_pkg::KIND_ABSOLUTE, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF,
                  16'hFFFF);
        send_word(sdik_pkg::KIND_CHASSIS, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_CHASSIS, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);

        // Phase one: sender idles a little, receiver a lot
        send_idle_pct = 19; recv_idle_pct = 71;
        load_regs(24'($urandom_range(200, 4000)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'd2, 16'd30,
                  {$urandom, $urandom}, 1'b0);
        for (int n = 0; n < 110; n++)
        begin
            send_random();
            if (n == 60)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
        end

        // Phase two: upper extremes, zero threshold; swap idling
        send_idle_pct = 71; recv_idle_pct = 19;
        load_regs(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  1'b1);
        send_word(sdik_pkg::KIND_CHASSIS, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_word(sdik_pkg::KIND_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        for (int n = 0; n < 110; n++) send_random();

        // Phase three: lower extremes, no idling
        send_idle_pct = 0; recv_idle_pct = 0;
        load_regs(24'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 64'h0, 1'b0);
        for (int n = 0; n < 60; n++) send_random();

        // Phase four: random settings, one long receiver hold-off
        load_regs(24'($urandom_range(24'hFFFFFF)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(64)),
                  16'($urandom_range(50)), {$urandom, $urandom}, 1'($urandom_range(1)));
        stall_requests++;
        for (int n = 0; n < 20; n++)
            send_word(sdik_pkg::KIND_READ, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        for (int n = 0; n < 150; n++) send_random();

        // Drain and finish
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (goal_board.pending() != 0) report("goals left over");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
